// File: rtl/aqi_pkg.sv
// Package for the particulate AQI core: breakpoint tables, reciprocals and shared types.
// No dependencies; aqi_sub_pipe, aqi_combine, the top level and the testbench import it.
`default_nettype none

package aqi_pkg;

	localparam int SEGS = 6;

	// Truncation to tenths or units: floor(x / 10) as (x * DIV10_MUL) >> DIV10_SHIFT.
	// The reciprocal is exact for every x below 2**18.
	localparam int DIV10_SHIFT = 20;
	localparam logic [16:0] DIV10_MUL = 17'd104858;
	localparam int CONC_W = 14;

	// Rounded interpolation: floor(n / d) as (n * R) >> RECIP_SHIFT, R = ceil(2**30 / d).
	// With n below 2**19 and d below 2**11 the error never reaches a whole step.
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W = 24;
	localparam int NUM_W = 18;
	localparam int RND_W = 19;
	localparam int PROD_W = RND_W + RECIP_W;

	localparam logic [1:0] DOM_NONE = 2'd0;
	localparam logic [1:0] DOM_FINE = 2'd1;
	localparam logic [1:0] DOM_COARSE = 2'd2;

	localparam logic signed [9:0] IDX_INVALID = -10'sd1;

	// PM2.5 in tenths of ug/m3.
	localparam logic [11:0] FINE_C_LO [SEGS] = '{12'd0, 12'd91, 12'd355, 12'd555, 12'd1255,
		12'd2255};
	localparam logic [11:0] FINE_C_HI [SEGS] = '{12'd90, 12'd354, 12'd554, 12'd1254, 12'd2254,
		12'd3254};
	localparam logic [8:0] FINE_I_LO [SEGS] = '{9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301};
	localparam logic [7:0] FINE_SLOPE [SEGS] = '{8'd50, 8'd49, 8'd49, 8'd49, 8'd99, 8'd199};
	localparam logic [9:0] FINE_SPAN [SEGS] = '{10'd90, 10'd263, 10'd199, 10'd699, 10'd999,
		10'd999};
	localparam logic [RECIP_W-1:0] FINE_RECIP [SEGS] = '{
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd180 - 64'd1) / 64'd180),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd526 - 64'd1) / 64'd526),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd398 - 64'd1) / 64'd398),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd1398 - 64'd1) / 64'd1398),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd1998 - 64'd1) / 64'd1998),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd1998 - 64'd1) / 64'd1998)};

	// PM10 in whole ug/m3.
	localparam logic [11:0] COARSE_C_LO [SEGS] = '{12'd0, 12'd55, 12'd155, 12'd255, 12'd355,
		12'd425};
	localparam logic [11:0] COARSE_C_HI [SEGS] = '{12'd54, 12'd154, 12'd254, 12'd354, 12'd424,
		12'd604};
	localparam logic [8:0] COARSE_I_LO [SEGS] = '{9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301};
	localparam logic [7:0] COARSE_SLOPE [SEGS] = '{8'd50, 8'd49, 8'd49, 8'd49, 8'd99, 8'd199};
	localparam logic [9:0] COARSE_SPAN [SEGS] = '{10'd54, 10'd99, 10'd99, 10'd99, 10'd69,
		10'd179};
	localparam logic [RECIP_W-1:0] COARSE_RECIP [SEGS] = '{
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd108 - 64'd1) / 64'd108),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd198 - 64'd1) / 64'd198),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd198 - 64'd1) / 64'd198),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd198 - 64'd1) / 64'd198),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd138 - 64'd1) / 64'd138),
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd358 - 64'd1) / 64'd358)};

	// One sub-index at the end of its third stage.
	typedef struct packed {
		logic ok;
		logic [8:0] i_lo;
		logic [PROD_W-1:0] prod;
	} sub_s3_t;

endpackage

`default_nettype wire

// File: rtl/aqi_if.sv
// Channel interfaces of the particulate AQI core: reading in, indexes out.
// Depends on nothing; used by the top level.
`default_nettype none

interface aqi_in_if;
	logic valid;
	logic ready;
	logic meas_valid;
	logic signed [17:0] pm25_hundredths;
	logic signed [17:0] pm10_tenths;

	modport source (output valid, meas_valid, pm25_hundredths, pm10_tenths, input ready);
	modport sink (input valid, meas_valid, pm25_hundredths, pm10_tenths, output ready);
endinterface

interface aqi_out_if;
	logic valid;
	logic ready;
	logic [8:0] overall_index;
	logic signed [9:0] fine_index;
	logic signed [9:0] coarse_index;
	logic [1:0] dominant;
	logic index_valid;

	modport source (output valid, overall_index, fine_index, coarse_index, dominant,
		index_valid, input ready);
	modport sink (input valid, overall_index, fine_index, coarse_index, dominant,
		index_valid, output ready);
endinterface

`default_nettype wire

// File: rtl/aqi_sub_pipe.sv
// Three-stage sub-index datapath for one pollutant: truncation, segment and slope, rounding.
// Depends on aqi_pkg.
`default_nettype none

module aqi_sub_pipe
	import aqi_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic coarse,
	input wire logic ok,
	input wire logic [16:0] conc,
	output sub_s3_t sub_s3
);

	// Stage 1: reciprocal product for the divide by ten.
	logic ok_s1;
	logic [33:0] prod_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= ok;
			prod_s1 <= 34'(conc) * 34'(DIV10_MUL);
		end
	end

	// Stage 2: segment search, clamp and slope product.
	logic [CONC_W-1:0] c_trunc;
	logic [2:0] seg;
	logic [11:0] c_clamp;
	logic [11:0] c_lo_sel;
	logic [11:0] c_hi_top;
	logic [7:0] slope_sel;
	logic [9:0] diff;
	logic [NUM_W-1:0] num_d;

	assign c_trunc = prod_s1[DIV10_SHIFT +: CONC_W];

	always_comb begin
		seg = 3'(SEGS - 1);
		for (int i = SEGS - 1; i >= 0; i--) begin
			if ({2'b00, (coarse ? COARSE_C_HI[i] : FINE_C_HI[i])} >= c_trunc) begin
				seg = 3'(i);
			end
		end
		c_hi_top = coarse ? COARSE_C_HI[SEGS-1] : FINE_C_HI[SEGS-1];
		c_clamp = (c_trunc > {2'b00, c_hi_top}) ? c_hi_top : c_trunc[11:0];
		c_lo_sel = coarse ? COARSE_C_LO[seg] : FINE_C_LO[seg];
		slope_sel = coarse ? COARSE_SLOPE[seg] : FINE_SLOPE[seg];
		diff = 10'(c_clamp - c_lo_sel);
		num_d = NUM_W'(diff) * NUM_W'(slope_sel);
	end

	logic ok_s2;
	logic [2:0] seg_s2;
	logic [NUM_W-1:0] num_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2 <= ok_s1;
			seg_s2 <= seg;
			num_s2 <= num_d;
		end
	end

	// Stage 3: (2 * num + span) times the reciprocal of 2 * span.
	logic [RND_W-1:0] rnd;
	logic [9:0] span_sel;
	logic [RECIP_W-1:0] recip_sel;

	always_comb begin
		span_sel = coarse ? COARSE_SPAN[seg_s2] : FINE_SPAN[seg_s2];
		recip_sel = coarse ? COARSE_RECIP[seg_s2] : FINE_RECIP[seg_s2];
		rnd = {num_s2, 1'b0} + RND_W'(span_sel);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sub_s3.ok <= ok_s2;
			sub_s3.i_lo <= coarse ? COARSE_I_LO[seg_s2] : FINE_I_LO[seg_s2];
			sub_s3.prod <= PROD_W'(rnd) * PROD_W'(recip_sel);
		end
	end

endmodule

`default_nettype wire

// File: rtl/aqi_combine.sv
// Fourth stage: finishes both sub-indexes, picks the dominant one and holds the result.
// Depends on aqi_pkg.
`default_nettype none

module aqi_combine
	import aqi_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input sub_s3_t fine_s3,
	input sub_s3_t coarse_s3,
	output logic [8:0] overall_s4,
	output logic signed [9:0] fine_s4,
	output logic signed [9:0] coarse_s4,
	output logic [1:0] dominant_s4,
	output logic index_valid_s4
);

	logic [8:0] fi;
	logic [8:0] ci;
	logic fine_wins;

	always_comb begin
		fi = fine_s3.i_lo + fine_s3.prod[RECIP_SHIFT +: 9];
		ci = coarse_s3.i_lo + coarse_s3.prod[RECIP_SHIFT +: 9];
		fine_wins = fine_s3.ok && (!coarse_s3.ok || fi >= ci);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fine_s4 <= fine_s3.ok ? $signed({1'b0, fi}) : IDX_INVALID;
			coarse_s4 <= coarse_s3.ok ? $signed({1'b0, ci}) : IDX_INVALID;
			if (fine_wins) begin
				overall_s4 <= fi;
				dominant_s4 <= DOM_FINE;
			end else if (coarse_s3.ok) begin
				overall_s4 <= ci;
				dominant_s4 <= DOM_COARSE;
			end else begin
				overall_s4 <= 9'd0;
				dominant_s4 <= DOM_NONE;
			end
			index_valid_s4 <= fine_s3.ok || coarse_s3.ok;
		end
	end

endmodule

`default_nettype wire

// File: rtl/us_aqi_from_particulates_core.sv
// US AQI from PM2.5 and PM10 as a four-stage pipeline; uses aqi_pkg, aqi_if,
// aqi_sub_pipe and aqi_combine.
// Throughput: one reading per cycle, since every stage takes a new item at each enabled edge.
// A stall on the output freezes every stage together, so items are held, never lost.
// Reset (arst_n low, asynchronous) clears only the stage valid bits; data registers are free.
`default_nettype none

module us_aqi_from_particulates_core
	import aqi_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	aqi_in_if.sink reading,
	aqi_out_if.source indexes
);

	// The whole pipeline moves as one. It advances whenever the output register is empty
	// or its contents are taken in this cycle, so a reading can follow every cycle. A
	// bubble that reaches the output register is filled even while the sink holds back.
	logic en;
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;

	assign en = !vld_s4 || indexes.ready;
	assign reading.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= reading.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// A sub-index is computed only when the reading is valid and its concentration is
	// not negative; the sign bit alone decides, so any negative value counts as invalid.
	logic fine_ok;
	logic coarse_ok;

	assign fine_ok = reading.meas_valid && !reading.pm25_hundredths[17];
	assign coarse_ok = reading.meas_valid && !reading.pm10_tenths[17];

	// Both pollutants share one datapath design; the table select is tied off per instance.
	sub_s3_t fine_s3;
	sub_s3_t coarse_s3;

	aqi_sub_pipe u_fine (
		.clk(clk),
		.en(en),
		.coarse(1'b0),
		.ok(fine_ok),
		.conc(reading.pm25_hundredths[16:0]),
		.sub_s3(fine_s3)
	);

	aqi_sub_pipe u_coarse (
		.clk(clk),
		.en(en),
		.coarse(1'b1),
		.ok(coarse_ok),
		.conc(reading.pm10_tenths[16:0]),
		.sub_s3(coarse_s3)
	);

	// The last stage doubles as the output register.
	aqi_combine u_combine (
		.clk(clk),
		.en(en),
		.fine_s3(fine_s3),
		.coarse_s3(coarse_s3),
		.overall_s4(indexes.overall_index),
		.fine_s4(indexes.fine_index),
		.coarse_s4(indexes.coarse_index),
		.dominant_s4(indexes.dominant),
		.index_valid_s4(indexes.index_valid)
	);

	assign indexes.valid = vld_s4;

`ifndef NO_ASSERTIONS
	// With no sub-index the result must be the empty one.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !indexes.index_valid) |-> (indexes.overall_index == 9'd0 &&
		indexes.dominant == DOM_NONE && indexes.fine_index == IDX_INVALID &&
		indexes.coarse_index == IDX_INVALID))
		else $error("empty result carries a nonzero field");

	// PM2.5 dominant: overall equals it and PM10 is invalid or not larger.
	a_fine_dom: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && indexes.dominant == DOM_FINE) |-> (indexes.fine_index ==
		$signed({1'b0, indexes.overall_index}) && (indexes.coarse_index == IDX_INVALID ||
		indexes.coarse_index <= indexes.fine_index)))
		else $error("PM2.5 marked dominant without winning");

	// PM10 dominant: overall equals it and PM2.5 is invalid or strictly smaller.
	a_coarse_dom: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && indexes.dominant == DOM_COARSE) |-> (indexes.coarse_index ==
		$signed({1'b0, indexes.overall_index}) && (indexes.fine_index == IDX_INVALID ||
		indexes.fine_index < indexes.coarse_index)))
		else $error("PM10 marked dominant without winning");
`endif

endmodule

`default_nettype wire

// File: sim/tb_us_aqi_from_particulates_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for us_aqi_from_particulates_core: directed and random readings.
// Depends on aqi_pkg, the channel interfaces in aqi_if and the core under test.

module tb_us_aqi_from_particulates_core;
	import aqi_pkg::DOM_NONE;
	import aqi_pkg::DOM_FINE;
	import aqi_pkg::DOM_COARSE;
	import aqi_pkg::IDX_INVALID;

	// Breakpoints of both tables. PM2.5 is in tenths of ug/m3 and PM10 in whole
	// ug/m3, which are the units left after the block truncates its inputs.
	localparam int PM25_LO [6] = '{0, 91, 355, 555, 1255, 2255};
	localparam int PM25_HI [6] = '{90, 354, 554, 1254, 2254, 3254};
	localparam int PM10_LO [6] = '{0, 55, 155, 255, 355, 425};
	localparam int PM10_HI [6] = '{54, 154, 254, 354, 424, 604};
	localparam int AQI_LO [6] = '{0, 51, 101, 151, 201, 301};
	localparam int AQI_HI [6] = '{50, 100, 150, 200, 300, 500};

	// A run is declared hung after this many cycles with no transfer on either channel.
	localparam int STUCK_LIMIT = 2000;
	// The pipeline is four stages deep; this is the settling time allowed at the end.
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_READINGS = 400;

	typedef struct packed {
		logic [8:0] overall;
		logic signed [9:0] fine;
		logic signed [9:0] coarse;
		logic [1:0] dom;
		logic ok;
	} aqi_result_t;

	// Works out the indexes of each accepted reading and holds them, oldest
	// first, until the block delivers the matching result.
	class aqi_ledger;
		aqi_result_t awaited[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Piecewise-linear EPA interpolation, rounded half up. Readings above the
		// top segment are clamped to its upper breakpoint, which gives 500.
		function int band_index(int conc, bit is_fine);
			int seg;
			int lo;
			int hi;
			int c;
			int span;
			seg = 5;
			for (int s = 5; s >= 0; s--) begin
				if (conc <= (is_fine ? PM25_HI[s] : PM10_HI[s]))
					seg = s;
			end
			lo = is_fine ? PM25_LO[seg] : PM10_LO[seg];
			hi = is_fine ? PM25_HI[seg] : PM10_HI[seg];
			c = (conc > hi) ? hi : conc;
			span = hi - lo;
			return AQI_LO[seg] +
				(2 * (AQI_HI[seg] - AQI_LO[seg]) * (c - lo) + span) / (2 * span);
		endfunction

		function aqi_result_t aqi_of_reading(logic meas_valid, logic signed [17:0] pm25,
				logic signed [17:0] pm10);
			aqi_result_t r;
			bit fine_ok;
			bit coarse_ok;
			int fi;
			int ci;
			fine_ok = meas_valid && (pm25 >= 0);
			coarse_ok = meas_valid && (pm10 >= 0);
			fi = fine_ok ? band_index(int'(pm25) / 10, 1'b1) : 0;
			ci = coarse_ok ? band_index(int'(pm10) / 10, 1'b0) : 0;
			r.fine = fine_ok ? 10'(fi) : IDX_INVALID;
			r.coarse = coarse_ok ? 10'(ci) : IDX_INVALID;
			// PM2.5 takes ties; an invalid reading or one with neither index left
			// reports zero with no dominant pollutant.
			if (fine_ok && (!coarse_ok || fi >= ci)) begin
				r.overall = 9'(fi);
				r.dom = DOM_FINE;
				r.ok = 1'b1;
			end else if (coarse_ok) begin
				r.overall = 9'(ci);
				r.dom = DOM_COARSE;
				r.ok = 1'b1;
			end else begin
				r.overall = '0;
				r.dom = DOM_NONE;
				r.ok = 1'b0;
			end
			return r;
		endfunction

		function void note_reading(logic meas_valid, logic signed [17:0] pm25,
				logic signed [17:0] pm10);
			awaited.push_back(aqi_of_reading(meas_valid, pm25, pm10));
		endfunction

		function void flag_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_indexes(aqi_result_t got);
			aqi_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got overall %0d", $time,
					got.overall);
				return;
			end
			want = awaited.pop_front();
			flag_field("overall_index", want.overall, got.overall);
			flag_field("fine_index", want.fine, got.fine);
			flag_field("coarse_index", want.coarse, got.coarse);
			flag_field("dominant", want.dom, got.dom);
			flag_field("index_valid", want.ok, got.ok);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit calm;
	int stuck_cycles;
	aqi_ledger ledger;

	aqi_in_if reading ();
	aqi_out_if indexes ();

	us_aqi_from_particulates_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.reading(reading),
		.indexes(indexes)
	);

	initial clk = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The result side holds back at random, with a chance of six in a hundred, except while the
	// stimulus runs a calm stretch in which neither side holds back.
	always @(negedge clk) begin
		indexes.ready <= calm || ($urandom_range(99) >= 6);
	end

	// Both channels are sampled at the rising edge, where the driven inputs have
	// been stable since the falling edge. A transfer on the input side records
	// its expected indexes; a transfer on the output side is checked against
	// the oldest record.
	always @(posedge clk) begin
		aqi_result_t seen;
		if (arst_n) begin
			if (reading.valid && reading.ready)
				ledger.note_reading(reading.meas_valid, reading.pm25_hundredths,
					reading.pm10_tenths);
			if (indexes.valid && indexes.ready) begin
				seen.overall = indexes.overall_index;
				seen.fine = indexes.fine_index;
				seen.coarse = indexes.coarse_index;
				seen.dom = indexes.dominant;
				seen.ok = indexes.index_valid;
				ledger.check_indexes(seen);
			end
		end
	end

	// Watchdog: any transfer restarts the count, so only a hung block trips it.
	always @(posedge clk) begin
		if (!arst_n || (reading.valid && reading.ready) || (indexes.valid && indexes.ready))
				begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Offers one reading and returns once it has been taken. Idle cycles are
	// inserted at random before the offer, so a gap can fall right after any
	// transfer. Valid stays high from one reading to the next when no gap is
	// drawn, which keeps the block running at full rate.
	task automatic send_reading(input logic meas_valid, input logic signed [17:0] pm25,
			input logic signed [17:0] pm10);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 6) begin
			reading.valid <= 1'b0;
			@(negedge clk);
		end
		reading.valid <= 1'b1;
		reading.meas_valid <= meas_valid;
		reading.pm25_hundredths <= pm25;
		reading.pm10_tenths <= pm10;
		@(posedge clk);
		while (!reading.ready)
			@(posedge clk);
	endtask

	// Draws one concentration in input units: hundredths for PM2.5, tenths for
	// PM10. Both scale the table units by ten, so one routine serves both.
	// Most values land in a chosen segment or straddle a breakpoint, where the
	// truncation and the rounding matter most; some run far past the top or are
	// negative.
	function automatic logic signed [17:0] draw_conc(bit is_fine);
		int roll;
		int seg;
		int top;
		roll = $urandom_range(99);
		seg = $urandom_range(5);
		top = (is_fine ? PM25_HI[5] : PM10_HI[5]) * 10;
		if (roll < 7)
			return -18'sd1;
		if (roll < 9)
			return 18'(-int'($urandom_range(131072, 2)));
		if (roll < 32)
			return 18'((is_fine ? PM25_HI[seg] : PM10_HI[seg]) * 10 +
				int'($urandom_range(24)) - 5);
		if (roll < 42)
			return 18'(int'($urandom_range(100000, top)));
		if (roll < 80)
			return 18'(int'($urandom_range((is_fine ? PM25_HI[seg] : PM10_HI[seg]) * 10 + 9,
				(is_fine ? PM25_LO[seg] : PM10_LO[seg]) * 10)));
		return 18'(int'($urandom_range(top + 9)));
	endfunction

	initial begin
		ledger = new();
		calm = 1'b0;
		arst_n = 1'b0;
		reading.valid = 1'b0;
		reading.meas_valid = 1'b0;
		reading.pm25_hundredths = '0;
		reading.pm10_tenths = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed readings. An invalid reading must report nothing even with good
		// concentrations; then missing pollutants, ties, clamping and the points
		// on either side of each breakpoint.
		send_reading(1'b0, 18'sd5000, 18'sd800);
		send_reading(1'b1, -18'sd1, -18'sd1);
		send_reading(1'b1, -18'sd1, 18'sd1234);
		send_reading(1'b1, 18'sd3456, -18'sd1);
		send_reading(1'b1, -18'sd131072, -18'sd2);
		send_reading(1'b1, 18'sd0, 18'sd0);
		send_reading(1'b1, 18'sd100000, 18'sd100000);
		send_reading(1'b1, 18'sd909, 18'sd549);
		send_reading(1'b1, 18'sd0, 18'sd6049);
		send_reading(1'b1, 18'sd910, 18'sd550);
		send_reading(1'b1, 18'sd3549, 18'sd1549);
		send_reading(1'b1, 18'sd3550, 18'sd1550);
		send_reading(1'b1, 18'sd5549, 18'sd2549);
		send_reading(1'b1, 18'sd5550, 18'sd2550);
		send_reading(1'b1, 18'sd12549, 18'sd3549);
		send_reading(1'b1, 18'sd12550, 18'sd3550);
		send_reading(1'b1, 18'sd22549, 18'sd4249);
		send_reading(1'b1, 18'sd22550, 18'sd4250);
		send_reading(1'b1, 18'sd32549, 18'sd6049);
		send_reading(1'b1, 18'sd32550, 18'sd6050);
		send_reading(1'b1, 18'sd131071, 18'sd131071);
		send_reading(1'b0, -18'sd1, -18'sd1);

		// Random readings, with a calm stretch in the middle in which neither
		// side idles, so back-to-back transfers run for a while.
		for (int n = 0; n < RANDOM_READINGS; n++) begin
			calm = (n >= 150 && n < 250);
			send_reading($urandom_range(99) >= 5, draw_conc(1'b1), draw_conc(1'b0));
		end
		calm = 1'b0;
		@(negedge clk);
		reading.valid <= 1'b0;

		// Drain: the watchdog bounds this wait if results stop coming.
		while (ledger.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (ledger.awaited.size() != 0)
				$display("%0t: %0d results never arrived", $time, ledger.awaited.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/aqi_pkg.sv
rtl/aqi_if.sv
rtl/aqi_sub_pipe.sv
rtl/aqi_combine.sv
rtl/us_aqi_from_particulates_core.sv
sim/tb_us_aqi_from_particulates_core.sv
